// ----- hw/rtl/cch_pkg.sv -----
// shared types and constants for the colour cube hit test
package cch_pkg;

    localparam int XW = 14;   // centred coordinate
    localparam int CW = 13;   // face edge vector component
    localparam int PW = 27;   // coordinate times component
    localparam int DW = 27;   // face denominator

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLACK  = 2'd2;

    localparam logic [11:0] RST_WIDTH  = 12'd200;
    localparam logic [11:0] RST_HEIGHT = 12'd200;

    // derived values for the reset height
    localparam logic signed [CW-1:0] RST_A  = 13'sd98;
    localparam logic signed [CW-1:0] RST_E  = 13'sd83;
    localparam logic signed [CW-1:0] RST_HA = 13'sd49;
    localparam logic signed [DW-1:0] RST_DEN = -27'sd8134;
    localparam logic [DW-1:0] RST_DABS = 27'd8134;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic                 dneg;
        logic                 dzero;
        logic [DW-1:0]        dabs;
    } face_t;

endpackage

// ----- hw/rtl/cch_cfg.sv -----
// configuration registers and the face geometry derived from them
module cch_cfg #(
    parameter int GRID_STEPS = 8,
    parameter int NW = 29 + $clog2(GRID_STEPS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [10:0]         cx,
    output logic [10:0]         cy,
    output logic                black,
    output cch_pkg::face_t      faces [3],
    output logic [NW-2:0]       ddabs [3]
);

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic        black_reg;

    logic signed [cch_pkg::CW-1:0] a_c, e_c, ha_c;
    logic [11:0]                   a_mag;
    logic [15:0]                   v_mag;
    logic [32:0]                   q_prod;
    logic [12:0]                   e_mag;

    logic signed [cch_pkg::CW-1:0] a_reg, e_reg, ha_reg;
    logic signed [cch_pkg::CW-1:0] fx1 [3];
    logic signed [cch_pkg::CW-1:0] fy1 [3];
    logic signed [cch_pkg::CW-1:0] fx2 [3];
    logic signed [cch_pkg::CW-1:0] fy2 [3];
    logic signed [cch_pkg::DW-1:0] den_reg [3];
    logic [cch_pkg::DW-1:0]        dabs_reg [3];
    logic [NW-2:0]                 ddabs_reg [3];

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cch_pkg::RST_WIDTH;
            height_reg <= cch_pkg::RST_HEIGHT;
            black_reg  <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                cch_pkg::REG_WIDTH:  width_reg  <= pwdata[11:0];
                cch_pkg::REG_HEIGHT: height_reg <= pwdata[11:0];
                cch_pkg::REG_BLACK:  black_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            cch_pkg::REG_WIDTH:  prdata = {20'd0, width_reg};
            cch_pkg::REG_HEIGHT: prdata = {20'd0, height_reg};
            cch_pkg::REG_BLACK:  prdata = {31'd0, black_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // side a, half width e and half side, truncating on the magnitude
    always_comb
    begin
        a_c    = $signed({2'b00, height_reg[11:1]}) - 13'sd2;
        a_mag  = a_c[12] ? 12'(-a_c) : a_c[11:0];
        v_mag  = 16'(a_mag) * 16'd17;
        // divide by twenty through the reciprocal, exact for 16-bit values
        q_prod = 33'(v_mag) * 33'd52429;
        e_mag  = q_prod[32:20];
        e_c    = a_c[12] ? -$signed(e_mag) : $signed(e_mag);
        ha_c   = a_c[12] ? -$signed({2'b00, a_mag[11:1]}) : $signed({2'b00, a_mag[11:1]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= cch_pkg::RST_A;
            e_reg  <= cch_pkg::RST_E;
            ha_reg <= cch_pkg::RST_HA;
        end
        else
        begin
            a_reg  <= a_c;
            e_reg  <= e_c;
            ha_reg <= ha_c;
        end
    end

    // edge vectors: red, green, blue
    always_comb
    begin
        fx1[0] = -e_reg;  fy1[0] = ha_reg;  fx2[0] = e_reg;   fy2[0] = ha_reg;
        fx1[1] = e_reg;   fy1[1] = ha_reg;  fx2[1] = '0;      fy2[1] = -a_reg;
        fx1[2] = '0;      fy1[2] = -a_reg;  fx2[2] = -e_reg;  fy2[2] = ha_reg;
    end

    for (genvar f = 0; f < 3; f++)
    begin : g_face
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                den_reg[f]   <= cch_pkg::RST_DEN;
                dabs_reg[f]  <= cch_pkg::RST_DABS;
                ddabs_reg[f] <= (NW-1)'(cch_pkg::RST_DABS) * (NW-1)'(GRID_STEPS);
            end
            else
            begin
                den_reg[f]   <= cch_pkg::DW'(fx1[f] * fy2[f]) - cch_pkg::DW'(fy1[f] * fx2[f]);
                dabs_reg[f]  <= den_reg[f][cch_pkg::DW-1] ? cch_pkg::DW'(-den_reg[f])
                                                          : cch_pkg::DW'(den_reg[f]);
                ddabs_reg[f] <= (NW-1)'(den_reg[f][cch_pkg::DW-1] ? -den_reg[f] : den_reg[f])
                                * (NW-1)'(GRID_STEPS);
            end
        end

        assign faces[f].x1    = fx1[f];
        assign faces[f].y1    = fy1[f];
        assign faces[f].x2    = fx2[f];
        assign faces[f].y2    = fy2[f];
        assign faces[f].dneg  = den_reg[f][cch_pkg::DW-1];
        assign faces[f].dzero = (dabs_reg[f] == '0);
        assign faces[f].dabs  = dabs_reg[f];
        assign ddabs[f]       = ddabs_reg[f];
    end

    assign cx    = width_reg[11:1];
    assign cy    = height_reg[11:1];
    assign black = black_reg;

endmodule

// ----- hw/rtl/cch_face.sv -----
// one rhombus face: cross products, range check and bit-per-stage cell divide
module cch_face #(
    parameter int GRID_STEPS = 8,
    parameter int QW = $clog2(GRID_STEPS),
    parameter int NW = 29 + $clog2(GRID_STEPS)
) (
    input  logic                          clk,
    input  logic [QW+2:0]                 en,
    input  logic signed [cch_pkg::XW-1:0] x,
    input  logic signed [cch_pkg::XW-1:0] y,
    input  cch_pkg::face_t                face,
    input  logic [NW-2:0]                 ddabs,
    output logic                          hit,
    output logic [QW-1:0]                 ci,
    output logic [QW-1:0]                 cj
);

    logic signed [cch_pkg::PW-1:0] xy2_reg, yx2_reg, xy1_reg, yx1_reg;
    logic signed [cch_pkg::PW:0]   di, dj;
    logic signed [NW-1:0]          ni, nj;
    logic signed [NW-1:0]          ni_reg, nj_reg;
    logic signed [NW-1:0]          dabs_s, ddabs_s;
    logic                          ok;

    logic [NW-2:0] ri_reg [QW+1];
    logic [NW-2:0] rj_reg [QW+1];
    logic [QW-1:0] qi_reg [QW+1];
    logic [QW-1:0] qj_reg [QW+1];
    logic          hit_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xy2_reg <= x * face.y2;
            yx2_reg <= y * face.x2;
            xy1_reg <= x * face.y1;
            yx1_reg <= y * face.x1;
        end
    end

    // the j denominator is the i denominator negated
    always_comb
    begin
        di = (cch_pkg::PW+1)'(xy2_reg) - (cch_pkg::PW+1)'(yx2_reg);
        dj = (cch_pkg::PW+1)'(xy1_reg) - (cch_pkg::PW+1)'(yx1_reg);
        ni = NW'(di) * $signed(NW'(GRID_STEPS));
        nj = NW'(dj) * $signed(NW'(GRID_STEPS));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ni_reg <= face.dneg ? -ni : ni;
            nj_reg <= face.dneg ? nj : -nj;
        end
    end

    // a truncated quotient in 0..D-1 means -den < num < D*den
    always_comb
    begin
        dabs_s  = $signed(NW'(face.dabs));
        ddabs_s = $signed({1'b0, ddabs});
        ok = !face.dzero
             && (ni_reg + dabs_s > 0) && (ni_reg < ddabs_s)
             && (nj_reg + dabs_s > 0) && (nj_reg < ddabs_s);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hit_reg[0] <= ok;
            ri_reg[0]  <= ni_reg[NW-1] ? '0 : ni_reg[NW-2:0];
            rj_reg[0]  <= nj_reg[NW-1] ? '0 : nj_reg[NW-2:0];
            qi_reg[0]  <= '0;
            qj_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = QW - 1 - k;
        logic [NW-2:0] dsh;
        logic          gi, gj;

        assign dsh = (NW-1)'(face.dabs) << B;
        assign gi  = (ri_reg[k] >= dsh);
        assign gj  = (rj_reg[k] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en[3+k])
            begin
                hit_reg[k+1] <= hit_reg[k];
                ri_reg[k+1]  <= gi ? ri_reg[k] - dsh : ri_reg[k];
                rj_reg[k+1]  <= gj ? rj_reg[k] - dsh : rj_reg[k];
                qi_reg[k+1]  <= qi_reg[k] | (QW'(gi) << B);
                qj_reg[k+1]  <= qj_reg[k] | (QW'(gj) << B);
            end
        end
    end

    assign hit = hit_reg[QW];
    assign ci  = qi_reg[QW];
    assign cj  = qj_reg[QW];

endmodule

// ----- hw/rtl/color_cube_hit_test.sv -----
// top level of the colour cube hit test pipeline
//
// channel   signals                              direction
// pos       pos_valid pos_ready pos_x pos_y      in
// pix       pix_valid pix_ready pixel_color hit  out
// cfg       psel penable pwrite paddr pwdata     in, prdata pready out
//
// one transfer per cycle sustained while pix_ready holds; each result passes
// through the centring register, the cross products, the range check, the
// one-bit-per-stage cell divide and the colour register before result valid
// each stage holds a valid bit and moves on when the stage after it is free,
// so a stall at the output fills bubbles first and drops nothing
// reset clears the valid bits and loads the register defaults
// after a register write, derived geometry settles through its own registers
module color_cube_hit_test #(
    parameter int GRID_STEPS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pos_valid,
    output logic        pos_ready,
    input  logic signed [12:0] pos_x,
    input  logic signed [12:0] pos_y,
    output logic        pix_valid,
    input  logic        pix_ready,
    output logic [14:0] pixel_color,
    output logic        hit
);

    localparam int QW = $clog2(GRID_STEPS);
    localparam int NW = 29 + QW;
    localparam int NS = 5 + QW;

    logic [10:0]    cx, cy;
    logic           black;
    cch_pkg::face_t faces [3];
    logic [NW-2:0]  ddabs [3];

    logic [NS-1:0]  v_reg;
    logic [NS-1:0]  en;

    logic signed [cch_pkg::XW-1:0] x_reg, y_reg;

    logic          fhit [3];
    logic [QW-1:0] fi [3];
    logic [QW-1:0] fj [3];

    logic [4:0]  lvl [GRID_STEPS];
    logic [4:0]  li, lj;
    logic [14:0] sum;
    logic        any;
    logic [14:0] color_reg;
    logic        hit_reg;

    cch_cfg #(.GRID_STEPS(GRID_STEPS), .NW(NW)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cx      (cx),
        .cy      (cy),
        .black   (black),
        .faces   (faces),
        .ddabs   (ddabs)
    );

    // stage moves when empty or when the next one moves
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || pix_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= pos_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign pos_ready = en[0];
    assign pix_valid = v_reg[NS-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg <= cch_pkg::XW'(pos_x) - $signed({3'b000, cx});
            y_reg <= cch_pkg::XW'(pos_y) - $signed({3'b000, cy});
        end
    end

    for (genvar f = 0; f < 3; f++)
    begin : g_face
        cch_face #(.GRID_STEPS(GRID_STEPS), .QW(QW), .NW(NW)) u_face (
            .clk   (clk),
            .en    (en[QW+3:1]),
            .x     (x_reg),
            .y     (y_reg),
            .face  (faces[f]),
            .ddabs (ddabs[f]),
            .hit   (fhit[f]),
            .ci    (fi[f]),
            .cj    (fj[f])
        );
    end

    for (genvar k = 0; k < GRID_STEPS; k++)
    begin : g_lvl
        localparam int L = (31 * k) / (GRID_STEPS - 1);
        assign lvl[k] = 5'(L);
    end

    // faces in priority order red, green, blue
    always_comb
    begin
        any = 1'b1;
        if (fhit[0])
        begin
            li  = lvl[fi[0]];
            lj  = lvl[fj[0]];
            sum = {lj, li, 5'd0};
        end
        else if (fhit[1])
        begin
            li  = lvl[fi[1]];
            lj  = lvl[fj[1]];
            sum = {li, 5'd0, lj};
        end
        else if (fhit[2])
        begin
            li  = lvl[fi[2]];
            lj  = lvl[fj[2]];
            sum = {5'd0, lj, li};
        end
        else
        begin
            li  = '0;
            lj  = '0;
            sum = '0;
            any = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            hit_reg   <= any;
            color_reg <= !any ? 15'd0 : (black ? sum : ~sum);
        end
    end

    assign pixel_color = color_reg;
    assign hit         = hit_reg;

endmodule

// ----- verif/color_cube_hit_test_tb.sv -----
// self-checking testbench for the colour cube hit test block
`timescale 1ns / 1ps

module color_cube_hit_test_tb;

    localparam int STEPS = 8;
    localparam int LATENCY = 5 + $clog2(STEPS);
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [12:0] x;
        logic signed [12:0] y;
    } point_t;

    typedef struct packed {
        logic [14:0] color;
        logic        hit;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic pos_valid = 1'b0;
    logic pos_ready;
    logic signed [12:0] pos_x = '0;
    logic signed [12:0] pos_y = '0;
    logic pix_valid;
    logic pix_ready = 1'b0;
    logic [14:0] pixel_color;
    logic hit;

    // predictor copy of the registers
    logic [11:0] cur_width = cch_pkg::RST_WIDTH;
    logic [11:0] cur_height = cch_pkg::RST_HEIGHT;
    logic        cur_black = 1'b1;

    point_t pending_points[$];
    pixel_t expected_pixels[$];
    int     errors = 0;
    longint cycles = 0;
    int     send_gap = 0;
    int     stall_gap = 0;
    bit     busy_stretch = 0;

    color_cube_hit_test #(.GRID_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pos_valid(pos_valid), .pos_ready(pos_ready), .pos_x(pos_x), .pos_y(pos_y),
        .pix_valid(pix_valid), .pix_ready(pix_ready),
        .pixel_color(pixel_color), .hit(hit)
    );

    always #6 clk = ~clk;

    function automatic bit face_cell(input longint x, input longint y,
                                     input longint x1, input longint y1,
                                     input longint x2, input longint y2,
                                     output longint ci, output longint cj);
        longint den_i;
        longint den_j;
        den_i = x1 * y2 - y1 * x2;
        den_j = x2 * y1 - y2 * x1;
        ci = 0;
        cj = 0;
        if (den_i == 0 || den_j == 0)
            return 0;
        ci = (x * STEPS * y2 - y * STEPS * x2) / den_i;
        cj = (x * STEPS * y1 - y * STEPS * x1) / den_j;
        return ci >= 0 && ci < STEPS && cj >= 0 && cj < STEPS;
    endfunction

    function automatic longint channel_level(input longint k);
        return (31 * k) / (STEPS - 1);
    endfunction

    function automatic pixel_t colour_under(input point_t p);
        longint h, a, e, ha, x, y, ci, cj, sum;
        pixel_t r;
        h = longint'(cur_height);
        a = h / 2 - 2;
        e = (a * 17 / 10) / 2;
        ha = a / 2;
        x = longint'(p.x) - longint'(cur_width) / 2;
        y = longint'(p.y) - h / 2;
        r.hit = 1'b1;
        if (face_cell(x, y, -e, ha, e, ha, ci, cj))
            sum = (channel_level(ci) << 5) + (channel_level(cj) << 10);
        else if (face_cell(x, y, e, ha, 0, -a, ci, cj))
            sum = (channel_level(ci) << 10) + channel_level(cj);
        else if (face_cell(x, y, 0, -a, -e, ha, ci, cj))
            sum = channel_level(ci) + (channel_level(cj) << 5);
        else
            r.hit = 1'b0;
        if (!r.hit)
            r.color = '0;
        else
        begin
            if (!cur_black)
                sum = 32'h7FFF - sum;
            r.color = sum[14:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (busy_stretch || roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sender side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid <= 1'b0;
        end
        else
        begin
            if (pos_valid && pos_ready)
                expected_pixels.push_back(colour_under('{x: pos_x, y: pos_y}));
            if (!pos_valid || pos_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pos_valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    pos_x <= p.x;
                    pos_y <= p.y;
                    pos_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    pos_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ready <= 1'b0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel transfer with nothing expected: color %0h hit %0b",
                           pixel_color, hit);
                    errors++;
                end
                else
                begin
                    pixel_t want;
                    want = expected_pixels.pop_front();
                    if (pixel_color !== want.color)
                    begin
                        $error("pixel_color expected %0h actual %0h", want.color, pixel_color);
                        errors++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit expected %0b actual %0b", want.hit, hit);
                        errors++;
                    end
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap--;
                pix_ready <= 1'b0;
            end
            else
            begin
                pix_ready <= 1'b1;
                stall_gap = pick_gap();
            end
            if ($urandom_range(0, 199) == 0)
                busy_stretch = ~busy_stretch;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cch_pkg::REG_WIDTH:  cur_width = value[11:0];
            cch_pkg::REG_HEIGHT: cur_height = value[11:0];
            cch_pkg::REG_BLACK:  cur_black = value[0];
            default: ;
        endcase
    endtask

    // nothing queued, nothing waiting at the input and nothing in flight
    task automatic drain();
        wait (pending_points.size() == 0 && !pos_valid && expected_pixels.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic setup(input int w, input int h, input bit black);
        drain();
        write_reg(cch_pkg::REG_WIDTH, w);
        write_reg(cch_pkg::REG_HEIGHT, h);
        write_reg(cch_pkg::REG_BLACK, 32'(black));
        // wait for the derived geometry to settle after the writes
        repeat (4) @(posedge clk);
    endtask

    task automatic add_point(input longint x, input longint y);
        point_t p;
        p.x = x[12:0];
        p.y = y[12:0];
        pending_points.push_back(p);
    endtask

    // mostly points on or around the cube, the rest anywhere
    task automatic add_random(input int count);
        longint cx, cy, a, e, sx, sy;
        for (int n = 0; n < count; n++)
        begin
            cx = longint'(cur_width) / 2;
            cy = longint'(cur_height) / 2;
            a = cy - 2;
            e = (a * 17 / 10) / 2;
            sx = (e < 0 ? -e : e) + 3;
            sy = (a < 0 ? -a : a) + 3;
            if ($urandom_range(0, 9) < 8)
                add_point(cx - sx + longint'($urandom_range(0, 2 * sx)),
                          cy - sy + longint'($urandom_range(0, 2 * sy)));
            else
                add_point($urandom_range(0, 8191), $urandom_range(0, 8191));
        end
    endtask

    initial
    begin
        int w;
        int h;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: centre, face interiors, edges and field extremes
        add_point(100, 100);
        add_point(60, 130);
        add_point(140, 130);
        add_point(130, 70);
        add_point(70, 70);
        add_point(100, 51);
        add_point(100, 149);
        add_point(17, 100);
        add_point(183, 100);
        add_point(99, 99);
        add_point(-4096, -4096);
        add_point(4095, 4095);
        add_point(-4096, 4095);
        add_point(4095, -4096);
        add_point(0, 0);
        add_point(-1, -1);
        add_point(100, 2);
        add_point(100, 198);
        add_random(60);

        setup(0, 8, 0);
        add_point(0, 4);
        add_point(1, 4);
        add_point(0, 5);
        add_point(-1, 3);
        add_random(50);

        setup(4095, 4095, 1);
        add_point(2047, 2047);
        add_point(1000, 2500);
        add_point(3000, 2500);
        add_point(2500, 1200);
        add_point(4095, 4095);
        add_random(60);

        setup(4095, 4095, 0);
        add_random(60);

        setup(200, 200, 0);
        add_random(60);

        setup(37, 9, 1);
        add_random(40);

        for (int k = 0; k < 4; k++)
        begin
            w = $urandom_range(0, 4095);
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 4095) : $urandom_range(8, 300);
            setup(w, h, 1'($urandom_range(0, 1)));
            add_random(30);
        end

        drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cch_pkg.sv
hw/rtl/cch_cfg.sv
hw/rtl/cch_face.sv
hw/rtl/color_cube_hit_test.sv
verif/color_cube_hit_test_tb.sv
